@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define SPPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define SPPD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/sppd_pkg.sv @@
// Types, widths and helpers for the point-to-plane distance pipeline.
package sppd_pkg;

  localparam int COORD_BITS = 32;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int NORM_BITS  = PROD_BITS + 1;
  localparam int MAGN_BITS  = NORM_BITS - 1;
  localparam int LO_BITS    = (MAGN_BITS + 1) / 2;
  localparam int HI_BITS    = MAGN_BITS - LO_BITS;
  localparam int SHI_BITS   = NORM_BITS - LO_BITS;
  localparam int SQP_BITS   = 2 * LO_BITS;
  localparam int DPP_BITS   = SHI_BITS + DIFF_BITS;
  localparam int NN_BITS    = 2 * MAGN_BITS + 2;
  localparam int ROOT_BITS  = NN_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 1;
  localparam int DOT_BITS   = NORM_BITS + DIFF_BITS + 2;
  localparam int OUT_BITS   = 48;
  localparam int QUO_BITS   = OUT_BITS - 1;
  localparam int NUMH_BITS  = DOT_BITS - QUO_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;

  typedef struct packed {
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v3_x;
    coord_t v3_y;
    coord_t v3_z;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] distance;
    logic                       degenerate;
  } out_t;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'({a[COORD_BITS-1], a}) - diff_t'({b[COORD_BITS-1], b});
  endfunction

endpackage

@@ hw/rtl/signed_point_plane_distance_top.sv @@
// Signed distance from a point to a triangle's plane, fully pipelined.
//
// Input channel in_valid/in_stall/in_data carries the three vertices and the
// query point (signed fixed point). Output channel out_valid/out_stall/out_data
// carries the signed distance and a degenerate flag (zero normal, distance 0).
// An item is taken on an edge where valid is high and stall is low.
//
// Throughput: one item per clock while no waiting result is stalled. The
// pipeline depth is set by the 67-stage integer square root (one root bit
// per stage) and the 47-stage restoring divider (one quotient bit per
// stage), plus eight stages of subtract, multiply and sum, an overflow
// compare stage and the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated. Synchronous reset
// (rst_n low) clears every valid bit; data registers are not reset.
module signed_point_plane_distance_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sppd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sppd_pkg::out_t out_data
);

  localparam int RB = sppd_pkg::ROOT_BITS;
  localparam int QB = sppd_pkg::QUO_BITS;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: edge vectors and point offset
  sppd_pkg::diff_t a_r [3];
  sppd_pkg::diff_t b_r [3];
  sppd_pkg::diff_t d1_r [3];
  logic v1_r;
  // Stage 2: cross product terms
  logic signed [sppd_pkg::PROD_BITS-1:0] p_r [6];
  sppd_pkg::diff_t d2_r [3];
  logic v2_r;
  // Stage 3: normal
  logic signed [sppd_pkg::NORM_BITS-1:0] n3_r [3];
  sppd_pkg::diff_t d3_r [3];
  logic v3_r;
  // Stage 4: normal magnitude per component
  logic [sppd_pkg::MAGN_BITS-1:0] m4_r [3];
  logic signed [sppd_pkg::NORM_BITS-1:0] n4_r [3];
  sppd_pkg::diff_t d4_r [3];
  logic dg4_r, v4_r;
  // Stage 5: partial products
  logic [sppd_pkg::SQP_BITS-1:0] hh_r [3];
  logic [sppd_pkg::SQP_BITS-1:0] hl_r [3];
  logic [sppd_pkg::SQP_BITS-1:0] ll_r [3];
  logic signed [sppd_pkg::DPP_BITS-1:0] ph_r [3];
  logic signed [sppd_pkg::DPP_BITS-1:0] pl_r [3];
  logic dg5_r, v5_r;
  // Stage 6: per-component square and dot term
  logic [sppd_pkg::NN_BITS-1:0] sq_r [3];
  logic signed [sppd_pkg::DOT_BITS-1:0] dc_r [3];
  logic dg6_r, v6_r;
  // Stage 7: sums
  logic [sppd_pkg::NN_BITS-1:0] nn_r;
  logic signed [sppd_pkg::DOT_BITS-1:0] dot_r;
  logic dg7_r, v7_r;

  // Square root pipeline, entry 0 is loaded from stage 7
  logic [sppd_pkg::NN_BITS-1:0]  sr_rad_r  [RB+1];
  logic [sppd_pkg::REM_BITS-1:0] sr_rem_r  [RB+1];
  logic [RB-1:0]                 sr_root_r [RB+1];
  logic [sppd_pkg::DOT_BITS-1:0] sr_num_r  [RB+1];
  logic sr_neg_r [RB+1];
  logic sr_dg_r  [RB+1];
  logic sr_v_r   [RB+1];

  // Divider pipeline, entry 0 is the overflow compare
  logic [sppd_pkg::REM_BITS-1:0] dv_rem_r [QB+1];
  logic [QB-1:0]                 dv_lo_r  [QB+1];
  logic [QB-1:0]                 dv_q_r   [QB+1];
  logic [RB-1:0]                 dv_mag_r [QB+1];
  logic dv_ovf_r [QB+1];
  logic dv_neg_r [QB+1];
  logic dv_dg_r  [QB+1];
  logic dv_v_r   [QB+1];

  sppd_pkg::out_t out_r;
  logic           out_v_r;

  sppd_pkg::coord_t v1c [3];
  sppd_pkg::coord_t v2c [3];
  sppd_pkg::coord_t v3c [3];
  sppd_pkg::coord_t ptc [3];

  always_comb begin
    v1c[0] = in_data.v1_x;    v1c[1] = in_data.v1_y;    v1c[2] = in_data.v1_z;
    v2c[0] = in_data.v2_x;    v2c[1] = in_data.v2_y;    v2c[2] = in_data.v2_z;
    v3c[0] = in_data.v3_x;    v3c[1] = in_data.v3_y;    v3c[2] = in_data.v3_z;
    ptc[0] = in_data.point_x; ptc[1] = in_data.point_y; ptc[2] = in_data.point_z;
  end

  // Valid bits for the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a_r[k]  <= sppd_pkg::sub_c(v2c[k], v1c[k]);
        b_r[k]  <= sppd_pkg::sub_c(v3c[k], v1c[k]);
        d1_r[k] <= sppd_pkg::sub_c(ptc[k], v1c[k]);
      end
      p_r[0] <= a_r[1] * b_r[2];
      p_r[1] <= a_r[2] * b_r[1];
      p_r[2] <= a_r[2] * b_r[0];
      p_r[3] <= a_r[0] * b_r[2];
      p_r[4] <= a_r[0] * b_r[1];
      p_r[5] <= a_r[1] * b_r[0];
      d2_r   <= d1_r;
      for (int k = 0; k < 3; k++) begin
        n3_r[k] <= {p_r[2*k][sppd_pkg::PROD_BITS-1], p_r[2*k]}
                 - {p_r[2*k+1][sppd_pkg::PROD_BITS-1], p_r[2*k+1]};
      end
      d3_r <= d2_r;
      for (int k = 0; k < 3; k++) begin
        m4_r[k] <= sppd_pkg::MAGN_BITS'(n3_r[k][sppd_pkg::NORM_BITS-1] ? -n3_r[k] : n3_r[k]);
      end
      n4_r  <= n3_r;
      d4_r  <= d3_r;
      dg4_r <= (n3_r[0] == '0) && (n3_r[1] == '0) && (n3_r[2] == '0);
      // Split each component into halves so no multiplier input exceeds 34 bits
      for (int k = 0; k < 3; k++) begin
        hh_r[k] <= sppd_pkg::SQP_BITS'(m4_r[k][sppd_pkg::MAGN_BITS-1:sppd_pkg::LO_BITS])
                 * sppd_pkg::SQP_BITS'(m4_r[k][sppd_pkg::MAGN_BITS-1:sppd_pkg::LO_BITS]);
        hl_r[k] <= sppd_pkg::SQP_BITS'(m4_r[k][sppd_pkg::MAGN_BITS-1:sppd_pkg::LO_BITS])
                 * sppd_pkg::SQP_BITS'(m4_r[k][sppd_pkg::LO_BITS-1:0]);
        ll_r[k] <= sppd_pkg::SQP_BITS'(m4_r[k][sppd_pkg::LO_BITS-1:0])
                 * sppd_pkg::SQP_BITS'(m4_r[k][sppd_pkg::LO_BITS-1:0]);
        ph_r[k] <= $signed(n4_r[k][sppd_pkg::NORM_BITS-1:sppd_pkg::LO_BITS]) * d4_r[k];
        pl_r[k] <= $signed({1'b0, n4_r[k][sppd_pkg::LO_BITS-1:0]}) * d4_r[k];
      end
      dg5_r <= dg4_r;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= (sppd_pkg::NN_BITS'(hh_r[k]) << (2 * sppd_pkg::LO_BITS))
                 + (sppd_pkg::NN_BITS'(hl_r[k]) << (sppd_pkg::LO_BITS + 1))
                 + sppd_pkg::NN_BITS'(ll_r[k]);
        dc_r[k] <= (sppd_pkg::DOT_BITS'(ph_r[k]) <<< sppd_pkg::LO_BITS)
                 + sppd_pkg::DOT_BITS'(pl_r[k]);
      end
      dg6_r <= dg5_r;
      nn_r  <= sq_r[0] + sq_r[1] + sq_r[2];
      dot_r <= dc_r[0] + dc_r[1] + dc_r[2];
      dg7_r <= dg6_r;
    end
  end

  // Stage 8: sign and magnitude of the dot product, root setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_v_r[0] <= 1'b0;
    end else if (adv) begin
      sr_v_r[0] <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_rad_r[0]  <= nn_r;
      sr_rem_r[0]  <= '0;
      sr_root_r[0] <= '0;
      sr_num_r[0]  <= sppd_pkg::DOT_BITS'(dot_r[sppd_pkg::DOT_BITS-1] ? -dot_r : dot_r);
      sr_neg_r[0]  <= dot_r[sppd_pkg::DOT_BITS-1];
      sr_dg_r[0]   <= dg7_r;
    end
  end

  // Floored square root, two radicand bits per stage
  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    logic [sppd_pkg::REM_BITS+1:0] cur;
    logic [sppd_pkg::REM_BITS+1:0] trial;
    logic                          ge;

    assign cur   = {sr_rem_r[i], sr_rad_r[i][sppd_pkg::NN_BITS-1 -: 2]};
    assign trial = {1'b0, sr_root_r[i], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v_r[i+1] <= 1'b0;
      end else if (adv) begin
        sr_v_r[i+1] <= sr_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_rem_r[i+1]  <= ge ? sppd_pkg::REM_BITS'(cur - trial) : sppd_pkg::REM_BITS'(cur);
        sr_root_r[i+1] <= {sr_root_r[i][RB-2:0], ge};
        sr_rad_r[i+1]  <= sr_rad_r[i] << 2;
        sr_num_r[i+1]  <= sr_num_r[i];
        sr_neg_r[i+1]  <= sr_neg_r[i];
        sr_dg_r[i+1]   <= sr_dg_r[i];
      end
    end
  end

  // Overflow check: quotient reaches 2^QB exactly when the high part of the
  // numerator is not below the root; otherwise that part seeds the remainder
  logic [sppd_pkg::NUMH_BITS-1:0] numh;
  assign numh = sr_num_r[RB][sppd_pkg::DOT_BITS-1:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sr_v_r[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0] <= sppd_pkg::REM_BITS'(numh);
      dv_ovf_r[0] <= sppd_pkg::REM_BITS'(numh) >= sppd_pkg::REM_BITS'(sr_root_r[RB]);
      dv_lo_r[0]  <= sr_num_r[RB][QB-1:0];
      dv_q_r[0]   <= '0;
      dv_mag_r[0] <= sr_root_r[RB];
      dv_neg_r[0] <= sr_neg_r[RB];
      dv_dg_r[0]  <= sr_dg_r[RB];
    end
  end

  // Restoring divide, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [sppd_pkg::REM_BITS:0] cur;
    logic [sppd_pkg::REM_BITS:0] magx;
    logic                        ge;

    assign cur  = {dv_rem_r[j], dv_lo_r[j][QB-1]};
    assign magx = {2'b00, dv_mag_r[j]};
    assign ge   = cur >= magx;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[j+1] <= ge ? sppd_pkg::REM_BITS'(cur - magx) : sppd_pkg::REM_BITS'(cur);
        dv_lo_r[j+1]  <= dv_lo_r[j] << 1;
        dv_q_r[j+1]   <= {dv_q_r[j][QB-2:0], ge};
        dv_mag_r[j+1] <= dv_mag_r[j];
        dv_ovf_r[j+1] <= dv_ovf_r[j];
        dv_neg_r[j+1] <= dv_neg_r[j];
        dv_dg_r[j+1]  <= dv_dg_r[j];
      end
    end
  end

  // Saturate, apply sign, force zero on a degenerate triangle
  logic [sppd_pkg::OUT_BITS-1:0] lim;
  logic [sppd_pkg::OUT_BITS-1:0] mag_q;
  sppd_pkg::out_t                out_nxt;

  always_comb begin
    lim   = dv_neg_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    mag_q = dv_ovf_r[QB] ? lim : {1'b0, dv_q_r[QB]};
    out_nxt.degenerate = dv_dg_r[QB];
    if (dv_dg_r[QB]) begin
      out_nxt.distance = '0;
    end else if (dv_neg_r[QB]) begin
      out_nxt.distance = $signed(-mag_q);
    end else begin
      out_nxt.distance = $signed(mag_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/sppd_checker.sv @@
// Port-level checker for the point-to-plane distance block, with its bind.
`include "assert_macros.svh"

module sppd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input sppd_pkg::out_t out_data
);

  `SPPD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output item dropped under stall")
  `SPPD_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data), "stalled item changed")
  `SPPD_ASSERT(a_degen_zero, out_valid && out_data.degenerate |-> out_data.distance == '0, "degenerate item with nonzero distance")
  `SPPD_ASSERT(a_stall_src, in_stall |-> out_valid && out_stall, "input stalled without output backpressure")
  `SPPD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind signed_point_plane_distance_top sppd_checker u_sppd_checker (.*);

@@ tb/signed_point_plane_distance_top_test.sv @@
// Self-checking testbench for the point-to-plane signed distance pipeline.
module signed_point_plane_distance_top_test;

  localparam int LATENCY = 123;
  localparam int WB = 256;
  localparam logic signed [WB-1:0] DIST_MAX = (256'sd1 <<< 47) - 1;
  localparam logic signed [WB-1:0] DIST_MIN = -(256'sd1 <<< 47);

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  sppd_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  sppd_pkg::out_t out_data;

  sppd_pkg::out_t expected_dist_q[$];
  int   mismatch_cnt;
  int   result_cnt;
  int   degen_cnt;
  int   sat_cnt;
  int   item_cnt;
  bit   no_idle;

  signed_point_plane_distance_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [WB-1:0] isqrt_floor(logic [WB-1:0] v);
    logic [WB-1:0] r;
    logic [WB-1:0] t;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      t = r | (256'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Expected plane distance with floored square root, truncating divide and 48-bit saturation.
  function automatic sppd_pkg::out_t plane_distance(sppd_pkg::in_t it);
    logic signed [WB-1:0] ax, ay, az, bx, by, bz, dx, dy, dz, nx, ny, nz;
    logic signed [WB-1:0] nn, dotp;
    logic [WB-1:0] mag, mag_dot, quo;
    logic signed [WB-1:0] sq;
    sppd_pkg::out_t res;
    ax = WB'(it.v2_x) - WB'(it.v1_x);
    ay = WB'(it.v2_y) - WB'(it.v1_y);
    az = WB'(it.v2_z) - WB'(it.v1_z);
    bx = WB'(it.v3_x) - WB'(it.v1_x);
    by = WB'(it.v3_y) - WB'(it.v1_y);
    bz = WB'(it.v3_z) - WB'(it.v1_z);
    dx = WB'(it.point_x) - WB'(it.v1_x);
    dy = WB'(it.point_y) - WB'(it.v1_y);
    dz = WB'(it.point_z) - WB'(it.v1_z);
    nx = ay * bz - az * by;
    ny = az * bx - ax * bz;
    nz = ax * by - ay * bx;
    nn = nx * nx + ny * ny + nz * nz;
    res = '0;
    if (nn == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    dotp = nx * dx + ny * dy + nz * dz;
    mag = isqrt_floor(nn);
    mag_dot = dotp < 0 ? -dotp : dotp;
    quo = mag_dot / mag;
    sq = dotp < 0 ? -$signed(quo) : $signed(quo);
    if (sq > DIST_MAX) sq = DIST_MAX;
    if (sq < DIST_MIN) sq = DIST_MIN;
    res.distance = sq[47:0];
    return res;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 25);
  endfunction

  // Send one item; hold it until taken. Valid stays high on return.
  task automatic send_item(sppd_pkg::in_t it);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_dist_q.push_back(plane_distance(it));
    item_cnt++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall <= idle_now();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_cnt++;
      if (out_data.degenerate) degen_cnt++;
      if (out_data.distance == DIST_MAX[47:0] || out_data.distance == DIST_MIN[47:0])
        sat_cnt++;
      if (expected_dist_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", out_data);
      end else begin
        sppd_pkg::out_t e;
        e = expected_dist_q.pop_front();
        if (e.distance !== out_data.distance || e.degenerate !== out_data.degenerate) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp dist %h degen %b, got dist %h degen %b",
                     e.distance, e.degenerate, out_data.distance, out_data.degenerate);
        end
      end
    end
  end

  function automatic sppd_pkg::coord_t rand_coord(int mode);
    case (mode)
      0: return sppd_pkg::coord_t'($urandom);
      1: return sppd_pkg::coord_t'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
      2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return sppd_pkg::coord_t'($signed($urandom_range(20)) - 10);
    endcase
  endfunction

  function automatic sppd_pkg::in_t rand_item();
    sppd_pkg::in_t it;
    int mode;
    mode = $urandom_range(3);
    it.v1_x = rand_coord(mode); it.v1_y = rand_coord(mode); it.v1_z = rand_coord(mode);
    it.v2_x = rand_coord(mode); it.v2_y = rand_coord(mode); it.v2_z = rand_coord(mode);
    it.v3_x = rand_coord(mode); it.v3_y = rand_coord(mode); it.v3_z = rand_coord(mode);
    it.point_x = rand_coord($urandom_range(3));
    it.point_y = rand_coord($urandom_range(3));
    it.point_z = rand_coord($urandom_range(3));
    // make some triangles collinear or coincident
    if ($urandom_range(9) == 0) begin
      it.v3_x = it.v2_x; it.v3_y = it.v2_y; it.v3_z = it.v2_z;
    end else if ($urandom_range(9) == 0) begin
      it.v2_x = it.v1_x; it.v2_y = it.v1_y; it.v2_z = it.v1_z;
    end
    return it;
  endfunction

  task automatic test_directed();
    sppd_pkg::in_t it;
    // unit triangle in z=0, point above and below
    it = '0;
    it.v2_x = 32'sh10000; it.v3_y = 32'sh10000;
    it.point_z = 32'sh30000;
    send_item(it);
    it.point_z = -32'sh30000;
    send_item(it);
    it.point_z = 32'sh7fffffff;
    send_item(it);
    it.point_z = 32'sh80000000;
    send_item(it);
    // all zero: degenerate
    send_item('0);
    // collinear vertices: degenerate
    it = '0;
    it.v2_x = 32'sh10000; it.v3_x = 32'sh20000; it.point_y = 32'sh5;
    send_item(it);
    // all ones and all extremes
    send_item('1);
    it = '0;
    it.v2_x = 32'sh7fffffff; it.v3_y = 32'sh7fffffff; it.v1_z = 32'sh80000000;
    it.point_z = 32'sh7fffffff;
    send_item(it);
    // tiny normal with far point: large distance
    it = '0;
    it.v1_x = 32'sh80000000; it.v1_y = 32'sh80000000; it.v1_z = 32'sh80000000;
    it.v2_x = 32'sh80000001; it.v2_y = 32'sh80000000; it.v2_z = 32'sh80000000;
    it.v3_x = 32'sh80000000; it.v3_y = 32'sh80000001; it.v3_z = 32'sh80000000;
    it.point_z = 32'sh7fffffff;
    send_item(it);
    it.point_z = 32'sh80000000;
    it.v1_z = 32'sh7fffffff; it.v2_z = 32'sh7fffffff; it.v3_z = 32'sh7fffffff;
    send_item(it);
    for (int i = 0; i < 8; i++) begin
      it = '0;
      it.v2_x = sppd_pkg::coord_t'(32'sh1 << (i * 4));
      it.v3_y = sppd_pkg::coord_t'(32'sh1 << (i * 4));
      it.point_z = sppd_pkg::coord_t'($urandom);
      send_item(it);
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_item(rand_item());
  endtask

  // Full-rate stretch with no idling on either side.
  task automatic test_back_to_back(int n);
    no_idle = 1'b1;
    test_random(n);
    no_idle = 1'b0;
  endtask

  // Let the pipeline empty out before sending more.
  task automatic test_pause_drain();
    test_random(50);
    drain();
    test_random(50);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    mismatch_cnt = 0;
    result_cnt = 0;
    degen_cnt = 0;
    sat_cnt = 0;
    item_cnt = 0;
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(500);
    test_back_to_back(300);
    test_pause_drain();
    test_random(400);
    drain();
    repeat (LATENCY + 20) @(negedge clk);
    $display("sent %0d items, checked %0d results", item_cnt, result_cnt);
    $display("degenerate triangles %0d, saturated distances %0d, mismatches %0d",
             degen_cnt, sat_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_dist_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
